>>> rtl/ptbp_pkg.sv
// ptbp_pkg: types and constants shared by the pixel threshold bit packer
// used by every module of the block, no dependencies

package ptbp_pkg;

	localparam int OUT_BITS = 8;
	localparam int POS_W    = 3;
	localparam int LUMA_W   = 18;

	localparam logic [LUMA_W-1:0] COEF_RED   = 18'd299;
	localparam logic [LUMA_W-1:0] COEF_GREEN = 18'd587;
	localparam logic [LUMA_W-1:0] COEF_BLUE  = 18'd114;
	localparam logic [LUMA_W-1:0] LUMA_SCALE = 18'd1000;

	localparam logic [7:0] ALPHA_OPAQUE_MIN = 8'd127;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FONT_MODE      = 1'b1;

	localparam logic [7:0]        THRESHOLD_RESET   = 8'd128;
	localparam logic [LUMA_W-1:0] THRESHOLD_X_RESET = 18'd128000;

	// one classified pixel as handed from front to back
	typedef struct packed {
		logic dark;
		logic transp;
		logic row_end;
		logic image_start;
	} pix_class_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/ptbp_front.sv
// ptbp_front: accepts pixels, computes scaled luma and classifies dark/transparent
// depends on ptbp_pkg

module ptbp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    red,
	input  logic [7:0]                    green,
	input  logic [7:0]                    blue,
	input  logic [7:0]                    alpha,
	input  logic                          row_end,
	input  logic                          image_start,
	input  logic [ptbp_pkg::LUMA_W-1:0]   thr_scaled,
	input  ptbp_pkg::q_status_t           q_status,
	output logic                          q_push,
	output ptbp_pkg::pix_class_t          q_item
);

	logic                        valid_s1;
	logic [ptbp_pkg::LUMA_W-1:0] luma_s1;
	logic                        transp_s1;
	logic                        row_end_s1;
	logic                        image_start_s1;
	logic                        advance;
	logic                        accept;
	logic [ptbp_pkg::LUMA_W-1:0] luma;

	assign advance = !valid_s1 || !q_status.full;
	assign full    = !advance;
	assign accept  = push && advance;

	assign luma = ptbp_pkg::LUMA_W'(red)   * ptbp_pkg::COEF_RED
	            + ptbp_pkg::LUMA_W'(green) * ptbp_pkg::COEF_GREEN
	            + ptbp_pkg::LUMA_W'(blue)  * ptbp_pkg::COEF_BLUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			luma_s1        <= luma;
			transp_s1      <= alpha < ptbp_pkg::ALPHA_OPAQUE_MIN;
			row_end_s1     <= row_end;
			image_start_s1 <= image_start;
		end
	end

	assign q_push              = valid_s1 && !q_status.full;
	assign q_item.dark         = luma_s1 < thr_scaled;
	assign q_item.transp       = transp_s1;
	assign q_item.row_end      = row_end_s1;
	assign q_item.image_start  = image_start_s1;

endmodule

>>> rtl/ptbp_queue.sv
// ptbp_queue: short queue of classified pixels between front and back
// depends on ptbp_pkg

module ptbp_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ptbp_pkg::pix_class_t item_in,
	input  logic                 pop,
	output ptbp_pkg::pix_class_t item_out,
	output ptbp_pkg::q_status_t  status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ptbp_pkg::pix_class_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = count_q == CNT_W'(DEPTH);
	assign status.empty = count_q == '0;
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign item_out     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= item_in;
		end
	end

endmodule

>>> rtl/ptbp_back.sv
// ptbp_back: packs classified pixels msb first into bytes, holds the result register
// depends on ptbp_pkg

module ptbp_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               font_mode,
	input  ptbp_pkg::pix_class_t               q_item,
	input  ptbp_pkg::q_status_t                q_status,
	output logic                               q_pop,
	input  logic                               pop,
	output logic                               empty,
	output logic [ptbp_pkg::OUT_BITS-1:0]      packed_byte,
	output logic                               row_last
);

	localparam logic [ptbp_pkg::POS_W-1:0] POS_FIRST = ptbp_pkg::POS_W'(ptbp_pkg::OUT_BITS - 1);

	logic [ptbp_pkg::OUT_BITS-1:0] pack_q;
	logic [ptbp_pkg::POS_W-1:0]    pos_q;
	logic                          first_row_q;
	logic                          out_valid_q;
	logic [ptbp_pkg::OUT_BITS-1:0] out_byte_q;
	logic                          out_last_q;

	logic [ptbp_pkg::OUT_BITS-1:0] pack_cur;
	logic [ptbp_pkg::POS_W-1:0]    pos_cur;
	logic                          first_cur;
	logic [ptbp_pkg::OUT_BITS-1:0] pack_new;
	logic [ptbp_pkg::POS_W-1:0]    pos_new;
	logic                          first_new;
	logic                          emit;
	logic                          byte_full;
	logic                          skip;

	// pixels that give no byte never wait on the result register
	assign q_pop = !q_status.empty && (!emit || !out_valid_q || pop);

	always_comb begin
		pack_cur  = q_item.image_start ? '0 : pack_q;
		pos_cur   = q_item.image_start ? POS_FIRST : pos_q;
		first_cur = q_item.image_start ? 1'b1 : first_row_q;
		skip      = font_mode && first_cur;
		pack_new  = pack_cur;
		pos_new   = pos_cur;
		first_new = first_cur;
		emit      = 1'b0;
		byte_full = font_mode ? (pos_cur == '0) : (pos_cur <= ptbp_pkg::POS_W'(1));
		if (skip) begin
			// metrics row in font mode
			if (q_item.row_end) begin
				first_new = 1'b0;
			end
		end else begin
			if (q_item.dark) begin
				pack_new = pack_new | (ptbp_pkg::OUT_BITS'(1) << pos_cur);
			end
			if (!font_mode && pos_cur != '0 && q_item.transp) begin
				pack_new = pack_new | (ptbp_pkg::OUT_BITS'(1) << (pos_cur - 1'b1));
			end
			emit = byte_full || q_item.row_end;
			if (!byte_full) begin
				pos_new = font_mode ? pos_cur - ptbp_pkg::POS_W'(1)
				                    : pos_cur - ptbp_pkg::POS_W'(2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q      <= '0;
			pos_q       <= POS_FIRST;
			first_row_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				if (emit) begin
					pack_q      <= '0;
					pos_q       <= POS_FIRST;
					first_row_q <= q_item.row_end ? 1'b0 : first_new;
				end else begin
					pack_q      <= pack_new;
					pos_q       <= pos_new;
					first_row_q <= first_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			out_byte_q <= pack_new;
			out_last_q <= q_item.row_end;
		end
	end

	assign empty       = !out_valid_q;
	assign packed_byte = out_byte_q;
	assign row_last    = out_last_q;

endmodule

>>> rtl/pixel_threshold_bit_packer_top.sv
// pixel_threshold_bit_packer_top: luma threshold binarizer and bit packer, top level
// depends on ptbp_pkg, ptbp_front, ptbp_queue, ptbp_back
//
// channel   handshake        payload
// pixel     push / full      red, green, blue, alpha, row_end, image_start
// result    pop / empty      packed_byte, row_last
// config    cfg_we           cfg_index, cfg_data
//
// one pixel per cycle sustained while full stays low; a pixel reaches the result
// register through the luma register, the queue and the packer register
// asynchronous reset empties the pipeline and restores threshold 128, image mode
// a stalled result fills the queue, then full rises; pixels that give no byte still pass

module pixel_threshold_bit_packer_top #(
	parameter int Q_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [7:0]                            red,
	input  logic [7:0]                            green,
	input  logic [7:0]                            blue,
	input  logic [7:0]                            alpha,
	input  logic                                  row_end,
	input  logic                                  image_start,
	input  logic                                  pop,
	output logic                                  empty,
	output logic [ptbp_pkg::OUT_BITS-1:0]         packed_byte,
	output logic                                  row_last,
	input  logic                                  cfg_we,
	input  logic [ptbp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [7:0]                            cfg_data
);

	logic [ptbp_pkg::LUMA_W-1:0] thr_scaled_q;
	logic                        font_mode_q;
	logic                        q_push;
	logic                        q_pop;
	ptbp_pkg::pix_class_t        q_in;
	ptbp_pkg::pix_class_t        q_out;
	ptbp_pkg::q_status_t         q_status;

	// threshold kept pre-scaled by 1000
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_scaled_q <= ptbp_pkg::THRESHOLD_X_RESET;
			font_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptbp_pkg::REG_DARK_THRESHOLD: begin
					thr_scaled_q <= ptbp_pkg::LUMA_W'(cfg_data) * ptbp_pkg::LUMA_SCALE;
				end
				ptbp_pkg::REG_FONT_MODE: begin
					font_mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	ptbp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.alpha       (alpha),
		.row_end     (row_end),
		.image_start (image_start),
		.thr_scaled  (thr_scaled_q),
		.q_status    (q_status),
		.q_push      (q_push),
		.q_item      (q_in)
	);

	ptbp_queue #(
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.item_in  (q_in),
		.pop      (q_pop),
		.item_out (q_out),
		.status   (q_status)
	);

	ptbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.font_mode   (font_mode_q),
		.q_item      (q_out),
		.q_status    (q_status),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.packed_byte (packed_byte),
		.row_last    (row_last)
	);

endmodule

>>> rtl/ptbp_checker.sv
// ptbp_checker: port-level assertions for the bit packer, bound to the top level
// depends on ptbp_pkg and pixel_threshold_bit_packer_top

module ptbp_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic                           pop,
	input  logic                           empty,
	input  logic [ptbp_pkg::OUT_BITS-1:0]  packed_byte,
	input  logic                           row_last
);

	// waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(packed_byte) && $stable(row_last)))
		else $error("result changed while stalled");

	// backpressure only grows behind a new request
	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a request");

	// an idle front cannot stall
	a_idle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose with no request pending");

	// reset leaves both sides empty
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> (empty && !full))
		else $error("block not cleared in reset");

endmodule

bind pixel_threshold_bit_packer_top ptbp_checker u_ptbp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.pop         (pop),
	.empty       (empty),
	.packed_byte (packed_byte),
	.row_last    (row_last)
);
